>>> hw/rtl/hfc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the half/single float converter.
// No dependencies; used by hfc_lzc and half_float_converter_top.

package hfc_pkg;

	// Half format field widths.
	localparam int unsigned HALF_MAN_W = 10;
	localparam int unsigned HALF_EXP_W = 5;
	// Width of a leading-zero count over the half mantissa (0 to 10).
	localparam int unsigned LZ_W       = 4;

	// Single format field widths.
	localparam int unsigned SGL_MAN_W  = 23;
	localparam int unsigned SGL_EXP_W  = 8;

	// Request direction.
	typedef enum logic {
		DIR_F32_TO_HALF = 1'b0,
		DIR_HALF_TO_F32 = 1'b1
	} dir_t;

	// Result class decided in the middle stage.
	typedef enum logic [2:0] {
		KIND_NAN,
		KIND_INF,
		KIND_ZERO,
		KIND_SUB,
		KIND_NORM
	} kind_t;

	// Rounding increment on the single magnitude (half of a half ulp).
	localparam logic [30:0] ROUND_INC   = 31'h0000_1000;
	// Single exponent limits around the half range.
	localparam logic [7:0]  EXP_OVF     = 8'd143;  // bias 127 - 15 + 31
	localparam logic [7:0]  EXP_SUB_MAX = 8'd112;  // bias 127 - 15
	localparam logic [7:0]  EXP_SUB_MIN = 8'd103;  // below this the shift reaches 11
	localparam logic [7:0]  EXP_SUB_SH  = 8'd113;
	localparam logic [7:0]  BIAS_DIFF   = 8'd112;
	localparam logic [31:0] F32_NAN     = 32'h7f80_0001;
	localparam logic [7:0]  F32_EXP_MAX = 8'hff;
	localparam logic [4:0]  HALF_EXP_MAX = 5'h1f;

endpackage

>>> hw/rtl/hfc_lzc.sv
`timescale 1ns / 1ps
// Leading-zero counter over a half-precision mantissa.
// Depends on hfc_pkg for the mantissa and count widths.

module hfc_lzc (
	input  logic [hfc_pkg::HALF_MAN_W-1:0] man,
	output logic [hfc_pkg::LZ_W-1:0]       lz
);

	// Scan from the low end so the highest set bit wins; all zero gives the full width.
	always_comb begin
		lz = hfc_pkg::LZ_W'(hfc_pkg::HALF_MAN_W);
		for (int i = 0; i < int'(hfc_pkg::HALF_MAN_W); i++) begin
			if (man[i]) begin
				lz = hfc_pkg::LZ_W'(int'(hfc_pkg::HALF_MAN_W) - 1 - i);
			end
		end
	end

endmodule

>>> hw/rtl/half_float_converter_top.sv
`timescale 1ns / 1ps
// Top level of the binary32 / binary16 bit-pattern converter.
// Depends on hfc_pkg and hfc_lzc.
//
// Usage:
// The input channel carries one request per accepted cycle: req_type picks the
// direction (0 converts a single-precision pattern to half, 1 converts the half
// pattern in data_in[15:0] to single) and data_in holds the source bits. A
// request is taken at a rising edge where in_valid is high and in_stall is low.
// The output channel returns exactly one data_out per request, in request
// order, taken at an edge where out_valid is high and out_stall is low. Half
// results sit in data_out[15:0] with the upper half zero.
// The datapath is a three-stage pipeline: stage one rounds the single magnitude
// and counts leading zeros of the half mantissa, stage two classifies the value
// and works out exponent and shift, stage three shifts and packs the result.
// out_valid is the valid bit of stage three, so a request is returned once it has
// passed the stage-one, stage-two and stage-three registers; with no stall
// from the receiver a new request is accepted every cycle.
// When the receiver holds out_stall, the pipeline keeps filling its empty
// stages and raises in_stall only once every stage holds a request, so nothing
// is dropped or repeated. Reset clears all stage valid bits; the pipeline is
// empty and ready as soon as reset is released.

module half_float_converter_top (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [31:0] data_in,
	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] data_out
);

	// Stage load enables. A stage loads when it is empty or its content moves on.
	logic load_s1, load_s2, load_s3;
	logic valid_s1, valid_s2, valid_s3;

	assign load_s3  = !valid_s3 || !out_stall;
	assign load_s2  = !valid_s2 || load_s3;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_stall = !load_s1;

	// ---------------------------------------------------------------------
	// Stage 1: rounding add on the single magnitude, leading-zero count for
	// the half mantissa, and the special-case flags of the raw input.
	// ---------------------------------------------------------------------
	logic [30:0]                    round_sum;
	logic [hfc_pkg::LZ_W-1:0]       lz_in;

	assign round_sum = data_in[30:0] + hfc_pkg::ROUND_INC;

	hfc_lzc u_lzc (
		.man (data_in[hfc_pkg::HALF_MAN_W-1:0]),
		.lz  (lz_in)
	);

	hfc_pkg::dir_t                    dir_s1;
	logic                             sign_s1;
	logic [17:0]                      rnd_s1;      // rounded exponent and top 10 mantissa bits
	logic                             f_exp_max_s1;
	logic                             f_exp_zero_s1;
	logic                             f_man_zero_s1;
	logic [hfc_pkg::HALF_EXP_W-1:0]   h_exp_s1;
	logic [hfc_pkg::HALF_MAN_W-1:0]   h_man_s1;
	logic [hfc_pkg::LZ_W-1:0]         lz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			dir_s1        <= hfc_pkg::dir_t'(req_type);
			sign_s1       <= req_type ? data_in[15] : data_in[31];
			rnd_s1        <= round_sum[30:13];
			f_exp_max_s1  <= (data_in[30:23] == hfc_pkg::F32_EXP_MAX);
			f_exp_zero_s1 <= (data_in[30:23] == 8'd0);
			f_man_zero_s1 <= (data_in[22:0] == 23'd0);
			h_exp_s1      <= data_in[14:10];
			h_man_s1      <= data_in[9:0];
			lz_s1         <= lz_in;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: classify the value, form the target exponent, the mantissa
	// to be shifted and the shift distance.
	// ---------------------------------------------------------------------
	hfc_pkg::kind_t kind_nx;
	logic [7:0]     exp_nx;
	logic [10:0]    man_nx;
	logic [3:0]     sh_nx;
	logic [7:0]     r_exp;
	logic [7:0]     sub_sh;

	assign r_exp  = rnd_s1[17:10];
	assign sub_sh = hfc_pkg::EXP_SUB_SH - r_exp;

	always_comb begin
		kind_nx = hfc_pkg::KIND_NORM;
		exp_nx  = 8'd0;
		man_nx  = {1'b0, h_man_s1};
		sh_nx   = 4'd0;
		if (dir_s1 == hfc_pkg::DIR_F32_TO_HALF) begin
			man_nx = {1'b1, rnd_s1[9:0]};
			if (f_exp_max_s1) begin
				// Infinity and NaN are judged on the input before rounding.
				kind_nx = f_man_zero_s1 ? hfc_pkg::KIND_INF : hfc_pkg::KIND_NAN;
			end else if (f_exp_zero_s1) begin
				kind_nx = hfc_pkg::KIND_ZERO;
			end else if (r_exp >= hfc_pkg::EXP_OVF) begin
				kind_nx = hfc_pkg::KIND_INF;
			end else if (r_exp < hfc_pkg::EXP_SUB_MIN) begin
				kind_nx = hfc_pkg::KIND_ZERO;
			end else if (r_exp <= hfc_pkg::EXP_SUB_MAX) begin
				kind_nx = hfc_pkg::KIND_SUB;
				sh_nx   = sub_sh[3:0];
			end else begin
				exp_nx  = r_exp - hfc_pkg::BIAS_DIFF;
			end
		end else begin
			if (h_exp_s1 == hfc_pkg::HALF_EXP_MAX) begin
				kind_nx = (h_man_s1 == '0) ? hfc_pkg::KIND_INF : hfc_pkg::KIND_NAN;
			end else if (h_exp_s1 == '0) begin
				if (h_man_s1 == '0) begin
					kind_nx = hfc_pkg::KIND_ZERO;
				end else begin
					// Leading one at bit 9 - lz; shifting by lz + 1 drops it.
					kind_nx = hfc_pkg::KIND_SUB;
					exp_nx  = hfc_pkg::BIAS_DIFF - 8'(lz_s1);
					sh_nx   = lz_s1 + 4'd1;
				end
			end else begin
				exp_nx = 8'(h_exp_s1) + hfc_pkg::BIAS_DIFF;
			end
		end
	end

	hfc_pkg::dir_t  dir_s2;
	hfc_pkg::kind_t kind_s2;
	logic           sign_s2;
	logic [7:0]     exp_s2;
	logic [10:0]    man_s2;
	logic [3:0]     sh_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			dir_s2  <= dir_s1;
			kind_s2 <= kind_nx;
			sign_s2 <= sign_s1;
			exp_s2  <= exp_nx;
			man_s2  <= man_nx;
			sh_s2   <= sh_nx;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: mantissa shift and packing into the target format.
	// ---------------------------------------------------------------------
	logic [31:0] pack_nx;
	logic [10:0] sub_half;
	logic [9:0]  sub_sgl;

	assign sub_half = man_s2 >> sh_s2;
	assign sub_sgl  = 10'(man_s2[9:0] << sh_s2);

	always_comb begin
		pack_nx = 32'd0;
		if (dir_s2 == hfc_pkg::DIR_F32_TO_HALF) begin
			case (kind_s2)
				hfc_pkg::KIND_NAN:  pack_nx = {16'd0, sign_s2, hfc_pkg::HALF_EXP_MAX, 10'd1};
				hfc_pkg::KIND_INF:  pack_nx = {16'd0, sign_s2, hfc_pkg::HALF_EXP_MAX, 10'd0};
				hfc_pkg::KIND_ZERO: pack_nx = {16'd0, sign_s2, 15'd0};
				hfc_pkg::KIND_SUB:  pack_nx = {16'd0, sign_s2, 5'd0, sub_half[9:0]};
				hfc_pkg::KIND_NORM: pack_nx = {16'd0, sign_s2, exp_s2[4:0], man_s2[9:0]};
				default:            pack_nx = 32'd0;
			endcase
		end else begin
			case (kind_s2)
				hfc_pkg::KIND_NAN:  pack_nx = hfc_pkg::F32_NAN;
				hfc_pkg::KIND_INF:  pack_nx = {sign_s2, hfc_pkg::F32_EXP_MAX, 23'd0};
				hfc_pkg::KIND_ZERO: pack_nx = {sign_s2, 31'd0};
				hfc_pkg::KIND_SUB:  pack_nx = {sign_s2, exp_s2, sub_sgl, 13'd0};
				hfc_pkg::KIND_NORM: pack_nx = {sign_s2, exp_s2, man_s2[9:0], 13'd0};
				default:            pack_nx = 32'd0;
			endcase
		end
	end

	hfc_pkg::dir_t dir_s3;
	logic [31:0]   data_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (load_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3 && valid_s2) begin
			dir_s3  <= dir_s2;
			data_s3 <= pack_nx;
		end
	end

	assign out_valid = valid_s3;
	assign data_out  = data_s3;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------

	// The input is held off only when every stage is full and the output is blocked.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && out_stall))
		else $error("in_stall raised while the pipeline has room");

	// A half result never sets the upper sixteen bits.
	a_half_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dir_s3 == hfc_pkg::DIR_F32_TO_HALF) |-> (data_out[31:16] == 16'd0))
		else $error("half result has upper bits set");

	// A subnormal, in either direction, is formed with a shift between one and ten.
	a_sub_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kind_s2 == hfc_pkg::KIND_SUB) |-> (sh_s2 != 4'd0 && sh_s2 <= 4'd10))
		else $error("subnormal shift out of range");

	// A blocked result stage keeps the stage behind it in place.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !load_s2) |=> (valid_s2 && $stable(exp_s2) && $stable(sh_s2)))
		else $error("stage two changed while blocked");

endmodule
